>>> rtl/sha256_pkg.sv
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data;
        logic       valid;
        logic       last;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINAL,
        ST_PAD,
        ST_EMIT
    } t_core_state;

    localparam logic [255:0] IV = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam int unsigned LEN_OFFSET = 56;

endpackage

>>> rtl/sha256_front.sv
// Input side: two-entry request queue between the ports and the core.
module sha256_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sha256_pkg::t_item   i_item,
    output logic                o_full,
    output logic                o_avail,
    output sha256_pkg::t_item   o_item,
    input  logic                i_take
);

    sha256_pkg::t_item r_buf [2];
    logic              r_wr;
    logic              r_rd;
    logic [1:0]        r_cnt;
    logic              w_push;
    logic              w_pop;

    // Items with neither flag do nothing; they are dropped here.
    assign w_push  = i_push && !o_full && (i_item.valid || i_item.last);
    assign w_pop   = i_take && o_avail;
    assign o_full  = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_item  = r_buf[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

>>> rtl/sha256_core.sv
// Back end: byte packing, one-round-per-cycle compression, padding, digest emit.
module sha256_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_avail,
    input  sha256_pkg::t_item  i_item,
    output logic               o_take,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [31:0]        o_digest_word,
    output logic [2:0]         o_word_index,
    output logic               o_last_word
);

    sha256_pkg::t_core_state r_state, n_state;

    logic [31:0] r_w [16];
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [63:0] r_len;
    logic [63:0] r_len_lat;
    logic [5:0]  r_pos;
    logic [5:0]  r_rnd;
    logic [3:0]  r_pad;
    logic [2:0]  r_oi;
    logic        r_byte_done;
    logic        r_after;  // 0: return to idle, 1: continue padding

    // Byte insertion request from item or padding sequencer
    logic        w_put;
    logic [7:0]  w_byte;
    logic        w_ld;

    // Round datapath
    logic [3:0]  w_t;
    logic [31:0] w_x15, w_x2, w_ws0, w_ws1, w_wt, w_e1, w_ch, w_t1, w_e0, w_maj;

    assign w_t   = r_rnd[3:0];
    assign w_x15 = r_w[w_t + 4'd1];
    assign w_x2  = r_w[w_t + 4'd14];
    assign w_ws0 = {w_x15[6:0], w_x15[31:7]} ^ {w_x15[17:0], w_x15[31:18]} ^ (w_x15 >> 3);
    assign w_ws1 = {w_x2[16:0], w_x2[31:17]} ^ {w_x2[18:0], w_x2[31:19]} ^ (w_x2 >> 10);
    assign w_wt  = (r_rnd < 6'd16) ? r_w[w_t]
                 : r_w[w_t] + w_ws0 + r_w[w_t + 4'd9] + w_ws1;
    assign w_e1  = {r_v[4][5:0], r_v[4][31:6]} ^ {r_v[4][10:0], r_v[4][31:11]}
                 ^ {r_v[4][24:0], r_v[4][31:25]};
    assign w_ch  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign w_t1  = r_v[7] + w_e1 + w_ch + sha256_pkg::ROUND_K[r_rnd] + w_wt;
    assign w_e0  = {r_v[0][1:0], r_v[0][31:2]} ^ {r_v[0][12:0], r_v[0][31:13]}
                 ^ {r_v[0][21:0], r_v[0][31:22]};
    assign w_maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);

    // Padding byte selection: 0x80, zeros to offset 56, then length bytes
    always_comb begin
        if (r_pad == 4'd0) begin
            w_byte = 8'h80;
        end else if (r_pos != 6'(sha256_pkg::LEN_OFFSET) && r_pad == 4'd1) begin
            w_byte = 8'h00;
        end else begin
            w_byte = r_len_lat[63 - 8*(32'(r_pos) - 56) -: 8];
        end
    end

    // Next state and handshake
    always_comb begin
        n_state = r_state;
        o_take  = 1'b0;
        w_put   = 1'b0;
        unique case (r_state)
            sha256_pkg::ST_IDLE: begin
                if (i_avail) begin
                    if (i_item.valid && !r_byte_done) begin
                        w_put = 1'b1;
                        if (r_pos == 6'd63) n_state = sha256_pkg::ST_ROUND;
                        else if (!i_item.last) o_take = 1'b1;
                    end else begin
                        o_take = 1'b1;
                        n_state = sha256_pkg::ST_PAD;
                    end
                end
            end
            sha256_pkg::ST_ROUND: begin
                if (r_rnd == 6'd63) n_state = sha256_pkg::ST_FINAL;
            end
            sha256_pkg::ST_FINAL: begin
                if (r_pad == 4'd3) begin
                    n_state = sha256_pkg::ST_EMIT;
                end else begin
                    n_state = r_after ? sha256_pkg::ST_PAD : sha256_pkg::ST_IDLE;
                    if (!r_after && r_byte_done && !i_item.last) o_take = 1'b1;
                end
            end
            sha256_pkg::ST_PAD: begin
                w_put = 1'b1;
                if (r_pos == 6'd63) begin
                    n_state = sha256_pkg::ST_ROUND;
                end
            end
            sha256_pkg::ST_EMIT: begin
                if (i_pop && r_oi == 3'd7) n_state = sha256_pkg::ST_IDLE;
            end
            default: n_state = sha256_pkg::ST_IDLE;
        endcase
    end

    assign w_ld = (r_state == sha256_pkg::ST_IDLE) ? i_item.valid : 1'b0;

    assign o_empty       = (r_state != sha256_pkg::ST_EMIT);
    assign o_digest_word = r_h[r_oi];
    assign o_word_index  = r_oi;
    assign o_last_word   = (r_oi == 3'd7);

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sha256_pkg::ST_IDLE;
            r_pos       <= '0;
            r_rnd       <= '0;
            r_len       <= '0;
            r_pad       <= '0;
            r_oi        <= '0;
            r_byte_done <= 1'b0;
            r_after     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_put) r_pos <= r_pos + 6'd1;
            if (r_state == sha256_pkg::ST_ROUND) r_rnd <= r_rnd + 6'd1;
            unique case (r_state)
                sha256_pkg::ST_IDLE: begin
                    if (i_avail && w_ld && !r_byte_done) begin
                        r_len <= r_len + 64'd8;
                        if (r_pos == 6'd63) begin
                            r_byte_done <= 1'b1;
                            r_after     <= 1'b0;
                        end else if (i_item.last) begin
                            r_byte_done <= 1'b1;
                        end
                    end else if (i_avail) begin
                        r_byte_done <= 1'b0;
                        r_pad       <= 4'd0;
                    end
                end
                sha256_pkg::ST_FINAL: begin
                    // Final block finished: go emit the digest
                    if (r_pad == 4'd3) begin
                        r_pad <= 4'd0;
                        r_len <= '0;
                    end
                    if (!r_after) begin
                        if (!r_byte_done || !i_item.last) r_byte_done <= 1'b0;
                    end
                end
                sha256_pkg::ST_PAD: begin
                    if (r_pos == 6'd63) begin
                        r_after <= (r_pad != 4'd2);
                        if (r_pad == 4'd2) r_pad <= 4'd3;
                        else if (r_pad == 4'd0) r_pad <= 4'd1;
                    end else if (r_pos == 6'd55) begin
                        r_pad <= 4'd2;
                    end else if (r_pad == 4'd0) begin
                        r_pad <= 4'd1;
                    end
                end
                sha256_pkg::ST_EMIT: begin
                    if (i_pop) r_oi <= r_oi + 3'd1;
                    if (i_pop && r_oi == 3'd7) r_byte_done <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Length latch when padding starts
    always_ff @(posedge i_clk) begin
        if (r_state == sha256_pkg::ST_IDLE && n_state == sha256_pkg::ST_PAD) begin
            r_len_lat <= r_len;
        end
    end

    // Block buffer and schedule window
    always_ff @(posedge i_clk) begin
        if (w_put) begin
            if (r_pos[1:0] == 2'd0) begin
                r_w[r_pos[5:2]] <= {(r_state == sha256_pkg::ST_PAD) ? w_byte : i_item.data,
                                    24'd0};
            end else begin
                r_w[r_pos[5:2]] <= r_w[r_pos[5:2]] | ({24'd0,
                    (r_state == sha256_pkg::ST_PAD) ? w_byte : i_item.data}
                    << (8 * (3 - r_pos[1:0])));
            end
        end else if (r_state == sha256_pkg::ST_ROUND) begin
            r_w[w_t] <= w_wt;
        end
    end

    // Working variables and chaining value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha256_pkg::IV[255 - 32*i -: 32];
                r_v[i] <= '0;
            end
        end else if (r_state == sha256_pkg::ST_ROUND) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + w_t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= w_t1 + w_e0 + w_maj;
        end else if (r_state == sha256_pkg::ST_FINAL) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= r_h[i] + r_v[i];
            end
        end else if (r_state == sha256_pkg::ST_EMIT) begin
            if (i_pop && r_oi == 3'd7) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= sha256_pkg::IV[255 - 32*i -: 32];
                end
            end
        end else if (n_state == sha256_pkg::ST_ROUND) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end
    end

endmodule

>>> rtl/sha256_message_hasher.sv
// Data path: each byte goes into the block buffer; each full block takes 64 rounds plus
// a final add into the chaining value; an end request pads and compresses
// one or two more blocks before the eight digest words appear.
// Bytes wait in the input queue while the single shared round unit is busy.
// Reset: synchronous active-low; chaining value to the initial vector, queues empty.
module sha256_message_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_msg_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    sha256_pkg::t_item w_in;
    sha256_pkg::t_item w_q;
    logic              w_avail;
    logic              w_take;

    assign w_in = '{data: i_msg_byte, valid: i_byte_valid, last: i_end_of_message};

    sha256_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (w_in),
        .o_full  (full),
        .o_avail (w_avail),
        .o_item  (w_q),
        .i_take  (w_take)
    );

    sha256_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_avail       (w_avail),
        .i_item        (w_q),
        .o_take        (w_take),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    // The last word flag goes with index seven only
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_last_word == (o_word_index == 3'd7)))
        else $error("last word flag mismatch");

    // Popping the last word ends the digest burst
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_last_word) |=> empty)
        else $error("digest burst did not end");

    // Word index advances by one on each pop
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && !o_last_word) |=> (!empty &&
            o_word_index == $past(o_word_index) + 3'd1))
        else $error("word index skipped");

endmodule
